/* hw/rtl/http_chunked_body_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top_defines
// assertion macros shared by the chunked body decoder
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HCBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HCBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/hcbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// types and constants shared by the chunked body decoder
// ----------------------------------------------------------------------------
package hcbd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_WIDTH       = 32;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    // one classified request byte, as held in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_cls;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_SIZE    = 4'b0010,
        PH_DATA    = 4'b0100,
        PH_TRAILER = 4'b1000
    } t_phase;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.data    = c;
        r.is_cr   = (c == CH_CR);
        r.is_lf   = (c == CH_LF);
        r.is_hex  = 1'b0;
        r.hex_val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.is_hex  = 1'b1;
            r.hex_val = 4'(c - 8'h37);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/hcbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_front
// accepts request bytes, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module hcbd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_in_byte,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output hcbd_pkg::t_cls    o_q_item
);

    hcbd_pkg::t_cls r_mem [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;
    logic           push, pop;

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    assign push = i_in_valid && o_in_ready;
    assign pop  = o_q_valid && i_q_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= hcbd_pkg::classify(i_in_byte);
        end
    end

endmodule

/* hw/rtl/hcbd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_back
// framing state machine: header skip, size lines, data, trailer, result register
// ----------------------------------------------------------------------------
module hcbd_back #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [hcbd_pkg::CFG_WIDTH-1:0] i_max_body_size,
    input  logic                           i_q_valid,
    output logic                           o_q_ready,
    input  hcbd_pkg::t_cls                 i_q_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_body_byte,
    output logic                           o_body_valid,
    output logic                           o_message_done,
    output logic                           o_too_large
);

    localparam int CmpW = (COUNT_WIDTH > hcbd_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                              : hcbd_pkg::CFG_WIDTH;

    hcbd_pkg::t_phase       r_phase, n_phase;
    logic [1:0]             r_hdr_match, n_hdr_match;
    logic                   r_prev_cr, n_prev_cr;
    logic [COUNT_WIDTH-1:0] r_size_acc, n_size_acc;
    logic                   r_dig_end, n_dig_end;
    logic                   r_line_ne, n_line_ne;
    logic [COUNT_WIDTH-1:0] r_chunk_left, n_chunk_left;
    logic [COUNT_WIDTH-1:0] r_body_total, n_body_total;

    logic                   r_out_valid;
    logic [7:0]             r_body_byte, n_body_byte;
    logic                   r_body_valid, n_body_valid;
    logic                   r_done, n_done;
    logic                   r_big, n_big;
    logic                   has_result;

    logic                   pop;
    logic                   line_end;
    logic                   ne_line, de_line;
    logic [COUNT_WIDTH-1:0] acc_line;
    logic [COUNT_WIDTH-1:0] chunk_dec;

    assign o_q_ready = !r_out_valid || i_out_ready;
    assign pop       = i_q_valid && o_q_ready;

    assign o_out_valid    = r_out_valid;
    assign o_body_byte    = r_body_byte;
    assign o_body_valid   = r_body_valid;
    assign o_message_done = r_done;
    assign o_too_large    = r_big;

    assign chunk_dec = r_chunk_left - COUNT_WIDTH'(1);

    // line byte update shared by size and trailer lines
    always_comb begin
        line_end = i_q_item.is_lf && r_prev_cr;
        // a pending cr that was not followed by lf is line content
        ne_line  = r_line_ne || r_prev_cr;
        de_line  = r_dig_end || r_prev_cr;
        acc_line = r_size_acc;
        if (!i_q_item.is_cr) begin
            ne_line = 1'b1;
            if (!de_line) begin
                if (i_q_item.is_hex) begin
                    if (r_size_acc[COUNT_WIDTH-1 -: 4] != 4'd0) begin
                        acc_line = '1;
                    end else begin
                        acc_line = {r_size_acc[COUNT_WIDTH-5:0], i_q_item.hex_val};
                    end
                end else begin
                    de_line = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_hdr_match  = r_hdr_match;
        n_prev_cr    = r_prev_cr;
        n_size_acc   = r_size_acc;
        n_dig_end    = r_dig_end;
        n_line_ne    = r_line_ne;
        n_chunk_left = r_chunk_left;
        n_body_total = r_body_total;
        has_result   = 1'b0;
        n_body_byte  = 8'd0;
        n_body_valid = 1'b0;
        n_done       = 1'b0;
        n_big        = 1'b0;
        unique case (r_phase)
            hcbd_pkg::PH_HEADER: begin
                if (r_hdr_match[0] ? i_q_item.is_lf : i_q_item.is_cr) begin
                    if (r_hdr_match == 2'd3) begin
                        n_hdr_match = 2'd0;
                        n_phase     = hcbd_pkg::PH_SIZE;
                        n_prev_cr   = 1'b0;
                        n_size_acc  = '0;
                        n_dig_end   = 1'b0;
                        n_line_ne   = 1'b0;
                    end else begin
                        n_hdr_match = r_hdr_match + 2'd1;
                    end
                end else begin
                    n_hdr_match = {1'b0, i_q_item.is_cr};
                end
            end
            hcbd_pkg::PH_SIZE: begin
                n_prev_cr  = i_q_item.is_cr;
                n_size_acc = acc_line;
                n_dig_end  = de_line;
                n_line_ne  = ne_line;
                if (line_end) begin
                    if (r_line_ne) begin
                        if (r_size_acc == '0) begin
                            n_phase = hcbd_pkg::PH_TRAILER;
                        end else begin
                            n_chunk_left = r_size_acc;
                            n_phase      = hcbd_pkg::PH_DATA;
                        end
                    end
                    n_prev_cr  = 1'b0;
                    n_size_acc = '0;
                    n_dig_end  = 1'b0;
                    n_line_ne  = 1'b0;
                end
            end
            hcbd_pkg::PH_DATA: begin
                if (r_body_total != '1) begin
                    n_body_total = r_body_total + COUNT_WIDTH'(1);
                end
                n_chunk_left = chunk_dec;
                if (chunk_dec == '0) begin
                    n_phase    = hcbd_pkg::PH_SIZE;
                    n_prev_cr  = 1'b0;
                    n_size_acc = '0;
                    n_dig_end  = 1'b0;
                    n_line_ne  = 1'b0;
                end
                has_result   = 1'b1;
                n_body_byte  = i_q_item.data;
                n_body_valid = 1'b1;
            end
            hcbd_pkg::PH_TRAILER: begin
                n_prev_cr  = i_q_item.is_cr;
                n_size_acc = acc_line;
                n_dig_end  = de_line;
                n_line_ne  = ne_line;
                if (line_end) begin
                    n_prev_cr  = 1'b0;
                    n_size_acc = '0;
                    n_dig_end  = 1'b0;
                    n_line_ne  = 1'b0;
                    if (!r_line_ne) begin
                        // empty trailer line ends the message, then rearm
                        has_result   = 1'b1;
                        n_done       = 1'b1;
                        n_big        = (i_max_body_size != '0) &&
                                       (CmpW'(r_body_total) > CmpW'(i_max_body_size));
                        n_phase      = hcbd_pkg::PH_HEADER;
                        n_hdr_match  = 2'd0;
                        n_chunk_left = '0;
                        n_body_total = '0;
                    end
                end
            end
            default: begin
                n_phase = hcbd_pkg::PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hcbd_pkg::PH_HEADER;
            r_hdr_match  <= 2'd0;
            r_prev_cr    <= 1'b0;
            r_size_acc   <= '0;
            r_dig_end    <= 1'b0;
            r_line_ne    <= 1'b0;
            r_chunk_left <= '0;
            r_body_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_phase      <= n_phase;
                r_hdr_match  <= n_hdr_match;
                r_prev_cr    <= n_prev_cr;
                r_size_acc   <= n_size_acc;
                r_dig_end    <= n_dig_end;
                r_line_ne    <= n_line_ne;
                r_chunk_left <= n_chunk_left;
                r_body_total <= n_body_total;
                r_out_valid  <= has_result;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && has_result) begin
            r_body_byte  <= n_body_byte;
            r_body_valid <= n_body_valid;
            r_done       <= n_done;
            r_big        <= n_big;
        end
    end

endmodule

/* hw/rtl/http_chunked_body_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP chunked request body, one raw byte per beat. The header is
// skipped up to the first CR LF CR LF; size lines give hex chunk sizes, chunk
// data comes out as body beats, and the empty line after the trailer gives
// one completion beat, with too_large set when the body total exceeds a
// nonzero max_body_size. The block sustains one byte per clock while i_out_ready
// holds: the front classifies each byte into a two-entry queue and the back
// state machine consumes one queued byte per cycle into a registered result
// slot, so a byte's result beat is valid from the cycle after the back takes
// it. Bytes that end no data and no message give no result beat. max_body_size
// is to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "http_chunked_body_decoder_top_defines.svh"

module http_chunked_body_decoder_top #(
    parameter int COUNT_WIDTH = hcbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [hcbd_pkg::CFG_WIDTH-1:0] i_cfg_wr_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_in_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [7:0]                     o_body_byte,
    output logic                           o_body_valid,
    output logic                           o_message_done,
    output logic                           o_too_large
);

    logic [hcbd_pkg::CFG_WIDTH-1:0] r_max_body_size;
    logic                           q_valid;
    logic                           q_ready;
    hcbd_pkg::t_cls                 q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_size <= '0;
        end else if (i_cfg_wr_en) begin
            r_max_body_size <= i_cfg_wr_data;
        end
    end

    hcbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    hcbd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_body_size (r_max_body_size),
        .i_q_valid       (q_valid),
        .o_q_ready       (q_ready),
        .i_q_item        (q_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_body_byte     (o_body_byte),
        .o_body_valid    (o_body_valid),
        .o_message_done  (o_message_done),
        .o_too_large     (o_too_large)
    );

    // result beats are either data or completion, never both
    `HCBD_ASSERT_NOW(a_data_not_done, o_out_valid && o_body_valid, !o_message_done && !o_too_large, "data beat carries completion flags")
    // too_large only on a completion beat and only with a limit set
    `HCBD_ASSERT_NOW(a_big_needs_limit, o_out_valid && o_too_large, o_message_done && (r_max_body_size != '0), "too_large without completion or limit")
    // a completion beat always rearms to header search, so no data beat follows at once
    `HCBD_ASSERT_NEXT(a_done_then_no_data, o_out_valid && o_message_done && i_out_ready, !(o_out_valid && o_body_valid), "data beat right after completion")

endmodule
